// File: hdl/sfsf_pkg.sv
// Shared constants, register codes and multiplier handshake types for the FIR sample filter.
`timescale 1ns / 1ps
`default_nettype none
package sfsf_pkg;
	localparam int TAPS_DEF   = 32;
	localparam int SAMPLE_W   = 12;
	localparam int GAIN_W     = 16;
	localparam int VAL_W      = 16;
	localparam int CODE_W     = 12;
	localparam int IDX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int MA_W  = 17;
	localparam int MB_W  = 16;
	localparam int MP_W  = 34;
	localparam int DIG_W = 4;
	localparam int ACC_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_HP_SEL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_OFFSET  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_OFFSET = 3'd4;

	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_COEF   = 1'b1;

	typedef struct packed {
		logic                   start;
		logic signed [MA_W-1:0] a;
		logic [MB_W-1:0]        b;
		logic                   b_signed;
	} mul_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [MP_W-1:0] prod;
	} mul_rsp_t;
endpackage
`default_nettype wire

// File: hdl/sfsf_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface sfsf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sfsf_pkg::CFG_IDX_W-1:0]  index;
	logic [sfsf_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/sfsf_item_if.sv
// Input item channel: sample or coefficient write with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface sfsf_item_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 cmd;
	logic [sfsf_pkg::SAMPLE_W-1:0]        sample;
	logic                                 coef_bank;
	logic [sfsf_pkg::IDX_W-1:0]           coef_index;
	logic signed [sfsf_pkg::VAL_W-1:0]    coef_value;

	modport source (output valid, cmd, sample, coef_bank, coef_index, coef_value, input ready);
	modport sink (input valid, cmd, sample, coef_bank, coef_index, coef_value, output ready);
endinterface
`default_nettype wire

// File: hdl/sfsf_result_if.sv
// Result channel: filtered code, filtered value and clip flag with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface sfsf_result_if;
	logic                              valid;
	logic                              ready;
	logic [sfsf_pkg::CODE_W-1:0]       filtered_code;
	logic signed [sfsf_pkg::VAL_W-1:0] filtered_value;
	logic                              saturated;

	modport source (output valid, filtered_code, filtered_value, saturated, input ready);
	modport sink (input valid, filtered_code, filtered_value, saturated, output ready);
endinterface
`default_nettype wire

// File: hdl/sfsf_dsmul.sv
// Digit-serial multiplier: signed multiplicand times 16-bit multiplier, one 4-bit digit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sfsf_dsmul (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sfsf_pkg::mul_req_t  req,
	output sfsf_pkg::mul_rsp_t  rsp
);
	import sfsf_pkg::*;

	localparam int N_DIG = MB_W / DIG_W;
	localparam int CNT_W = $clog2(N_DIG);
	localparam int H_W   = MA_W + DIG_W + 1;

	logic signed [MA_W-1:0]  a_q;
	logic [MB_W-1:0]         b_q;
	logic                    bs_q;
	logic                    run_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [H_W-1:0]   h_q;
	logic [MB_W-1:0]         l_q;
	logic                    last;
	logic signed [DIG_W:0]   ds;
	logic signed [H_W-1:0]   pd;
	logic signed [H_W-1:0]   t;

	assign last = (cnt_q == CNT_W'(N_DIG - 1));
	// top digit of a signed multiplier carries negative weight
	assign ds   = (last && bs_q) ? {b_q[DIG_W-1], b_q[DIG_W-1:0]} : {1'b0, b_q[DIG_W-1:0]};
	assign pd   = a_q * ds;
	assign t    = h_q + pd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q  <= cnt_q + 1'b1;
			run_q  <= !last;
			done_q <= last;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			b_q  <= req.b;
			bs_q <= req.b_signed;
			h_q  <= '0;
		end else if (run_q) begin
			b_q <= b_q >> DIG_W;
			h_q <= t >>> DIG_W;
			l_q <= {t[DIG_W-1:0], l_q[MB_W-1:DIG_W]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = {h_q[MP_W-MB_W-1:0], l_q};
endmodule
`default_nettype wire

// File: hdl/selectable_fir_sample_filter.sv
// Top level: sample mapping, TAPS-tap FIR with selectable bank, output rescaling.
// Flow: a sample transfer is mapped, then each tap is read and multiplied on one shared
// digit-serial multiplier, then the filter output is rescaled and registered to the output.
// Items are accepted only while idle, so a new sample waits until the previous result is out.
// Reset: registers to defaults, delay line reads zero until filled; coefficients undefined.
`timescale 1ns / 1ps
`default_nettype none
module selectable_fir_sample_filter #(
	parameter int TAPS = sfsf_pkg::TAPS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	sfsf_cfg_if.sink         cfg,
	sfsf_item_if.sink        item,
	sfsf_result_if.source    result
);
	import sfsf_pkg::*;

	localparam int AW = (TAPS > 2) ? $clog2(TAPS) : 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MAPGO = 4'd1;
	localparam logic [3:0] S_MAPW  = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_WAIT  = 4'd5;
	localparam logic [3:0] S_FIN   = 4'd6;
	localparam logic [3:0] S_SCGO  = 4'd7;
	localparam logic [3:0] S_SCW   = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0]               state_q;
	logic                     hp_sel_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [VAL_W-1:0]  in_off_q;
	logic [GAIN_W-1:0]        scale_q;
	logic [CODE_W-1:0]        out_off_q;

	logic [SAMPLE_W-1:0]      sample_q;
	logic signed [VAL_W-1:0]  x_q;
	logic signed [VAL_W-1:0]  y_q;
	logic [CODE_W-1:0]        code_q;
	logic                     sat_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [AW-1:0]            k_q;
	logic [AW-1:0]            wp_q;
	logic [AW-1:0]            fill_q;

	logic signed [VAL_W-1:0]  cmem [0:2**(AW+1)-1];
	logic signed [VAL_W-1:0]  hmem [0:2**AW-1];
	logic signed [VAL_W-1:0]  coef_rd_q;
	logic signed [VAL_W-1:0]  hist_rd_q;
	logic                     hist_ok_q;

	logic                     ov_q;
	logic [CODE_W-1:0]        res_code_q;
	logic signed [VAL_W-1:0]  res_val_q;
	logic                     res_sat_q;

	mul_req_t                 mreq;
	mul_rsp_t                 mrsp;

	logic                     item_xfer;
	logic                     coef_we;
	logic [AW-1:0]            hist_addr;
	logic signed [17:0]       xs;
	logic signed [VAL_W-1:0]  x_sat;
	logic signed [24:0]       yw;
	logic signed [VAL_W-1:0]  y_sat;
	logic                     y_clip;
	logic signed [22:0]       cs;
	logic [CODE_W-1:0]        c_sat;
	logic                     c_clip;

	sfsf_dsmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == S_IDLE);
	assign item_xfer  = item.valid && item.ready;
	assign coef_we    = item_xfer && (item.cmd == CMD_COEF) &&
		({1'b0, item.coef_index} < 9'(TAPS));
	assign hist_addr  = wp_q - k_q;

	assign result.valid          = ov_q;
	assign result.filtered_code  = res_code_q;
	assign result.filtered_value = res_val_q;
	assign result.saturated      = res_sat_q;

	// mapped sample, clipped to 16 bits
	assign xs = {{2{in_off_q[VAL_W-1]}}, in_off_q} + {6'b0, mrsp.prod[27:16]};
	always_comb begin
		if (xs[17:15] == 3'b000 || xs[17:15] == 3'b111) begin
			x_sat = xs[VAL_W-1:0];
		end else if (xs[17]) begin
			x_sat = 16'sh8000;
		end else begin
			x_sat = 16'sh7FFF;
		end
	end

	// filter output, Q5.27 down to Q4.12
	assign yw = acc_q[ACC_W-1:15];
	always_comb begin
		y_clip = !(yw[24:15] == '0 || yw[24:15] == '1);
		if (!y_clip) begin
			y_sat = yw[VAL_W-1:0];
		end else if (yw[24]) begin
			y_sat = 16'sh8000;
		end else begin
			y_sat = 16'sh7FFF;
		end
	end

	// rescaled code
	assign cs = {mrsp.prod[MP_W-1], mrsp.prod[MP_W-1:12]} + {11'b0, out_off_q};
	always_comb begin
		c_clip = 1'b0;
		c_sat  = cs[CODE_W-1:0];
		if (cs[22]) begin
			c_clip = 1'b1;
			c_sat  = '0;
		end else if (|cs[21:CODE_W]) begin
			c_clip = 1'b1;
			c_sat  = '1;
		end
	end

	always_comb begin
		mreq = '0;
		case (state_q)
			S_MAPGO: begin
				mreq.start    = 1'b1;
				mreq.a        = {5'b0, sample_q};
				mreq.b        = gain_q;
				mreq.b_signed = 1'b0;
			end
			S_MUL: begin
				mreq.start    = 1'b1;
				if (k_q == '0) begin
					mreq.a = MA_W'(x_q);
				end else if (hist_ok_q) begin
					mreq.a = MA_W'(hist_rd_q);
				end else begin
					mreq.a = '0;
				end
				mreq.b        = coef_rd_q;
				mreq.b_signed = 1'b1;
			end
			S_SCGO: begin
				mreq.start    = 1'b1;
				mreq.a        = MA_W'(y_q);
				mreq.b        = scale_q;
				mreq.b_signed = 1'b0;
			end
			default: mreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_sel_q  <= 1'b0;
			gain_q    <= 16'd16;
			in_off_q  <= '0;
			scale_q   <= 16'd2048;
			out_off_q <= 12'd2048;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_HP_SEL:     hp_sel_q  <= cfg.data[0];
				REG_IN_GAIN:    gain_q    <= cfg.data;
				REG_IN_OFFSET:  in_off_q  <= cfg.data;
				REG_OUT_SCALE:  scale_q   <= cfg.data;
				REG_OUT_OFFSET: out_off_q <= cfg.data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			cmem[{item.coef_bank, item.coef_index[AW-1:0]}] <= item.coef_value;
		end
		if (state_q == S_FIN) begin
			hmem[wp_q] <= x_q;
		end
		coef_rd_q <= cmem[{hp_sel_q, k_q}];
		hist_rd_q <= hmem[hist_addr];
		hist_ok_q <= (k_q != '0) && (k_q <= fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			wp_q    <= '0;
			fill_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (result.valid && result.ready && state_q != S_OUT) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_xfer && item.cmd == CMD_FILTER) begin
						state_q <= S_MAPGO;
					end
				end
				S_MAPGO: state_q <= S_MAPW;
				S_MAPW: begin
					if (mrsp.done) begin
						k_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_WAIT;
				S_WAIT: begin
					if (mrsp.done) begin
						if (k_q == AW'(TAPS - 1)) begin
							state_q <= S_FIN;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					wp_q <= wp_q + 1'b1;
					if (fill_q != AW'(TAPS - 1)) begin
						fill_q <= fill_q + 1'b1;
					end
					state_q <= S_SCGO;
				end
				S_SCGO: state_q <= S_SCW;
				S_SCW: begin
					if (mrsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ov_q || result.ready) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			sample_q <= item.sample;
		end
		if (state_q == S_MAPW && mrsp.done) begin
			x_q   <= x_sat;
			acc_q <= '0;
		end
		if (state_q == S_WAIT && mrsp.done) begin
			acc_q <= acc_q + ACC_W'(mrsp.prod);
		end
		if (state_q == S_FIN) begin
			y_q   <= y_sat;
			sat_q <= y_clip;
		end
		if (state_q == S_SCW && mrsp.done) begin
			code_q <= c_sat;
			sat_q  <= sat_q || c_clip;
		end
		if (state_q == S_OUT && (!ov_q || result.ready)) begin
			res_code_q <= code_q;
			res_val_q  <= y_q;
			res_sat_q  <= sat_q;
		end
	end
endmodule
`default_nettype wire
